@@ rtl/spv_pkg.sv @@
package spv_pkg;

  localparam int FRAC_BITS_DEF = 29;

  localparam int DAY_W = 22;
  localparam int OUT_W = 32;
  localparam int ANG_W = 32;
  localparam int Q_SHIFT = 30;

  // Long division of the offset numerator by the turn denominator.
  localparam int NUM_W     = 59;
  localparam int HEAD_W    = 43;
  localparam int TAIL_W    = NUM_W - HEAD_W;
  localparam int REM_W     = HEAD_W + 1;
  localparam int DIV_CELLS = TAIL_W + ANG_W;
  localparam int SUM_W     = NUM_W + 2;
  localparam int PROD_W    = 60;

  localparam logic [REM_W-1:0] TURN_DEN = 44'd13149000000000;
  // A whole multiple of the denominator that keeps every numerator positive.
  localparam logic signed [SUM_W-1:0] NUM_OFFSET = 61'sd215433216000000000;
  localparam logic signed [DAY_W:0] J2000_DAY = 23'sd2451545;

  localparam logic signed [36:0] RATE_LON  = 37'sd36000771285;
  localparam logic signed [36:0] RATE_ANOM = 37'sd35999050957;
  localparam logic signed [36:0] RATE_OBL  = -37'sd14610;

  localparam logic signed [SUM_W-1:0] BASE_LON  = 61'sd10243801500000;
  localparam logic signed [SUM_W-1:0] BASE_ANOM = 61'sd13058710200000;
  localparam logic signed [SUM_W-1:0] BASE_OBL  = 61'sd856109475000;

  localparam int CORDIC_STEPS = 30;
  localparam int XY_W = 34;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XY_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
    34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
    34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA,
    34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
    34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051, 34'sh00000029,
    34'sh00000014, 34'sh0000000A, 34'sh00000005, 34'sh00000003, 34'sh00000001
  };

  localparam logic signed [25:0]     LAM_C1   = 26'sd22846840;
  localparam logic signed [18:0]     LAM_C2   = 19'sd238609;
  localparam logic signed [XY_W-1:0] MAG_BASE = 34'sd1073892148;
  localparam logic signed [25:0]     MAG_C1   = 26'sd17942226;
  localparam logic signed [18:0]     MAG_C2   = 19'sd150324;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [TAIL_W-1:0] tail;
    logic [ANG_W-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] z;
    logic                   flip;
  } cordic_t;

  // Shift right, rounding halves away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
    logic signed [63:0] half;
    logic signed [63:0] res;
    if (s == 0) begin
      res = v;
    end else begin
      half = 64'sd1 <<< (s - 1);
      if (v >= 0) res = (v + half) >>> s;
      else        res = -((-v + half) >>> s);
    end
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] res;
    if (v > 64'sd2147483647)       res = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) res = 32'sh80000000;
    else                           res = v[OUT_W-1:0];
    return res;
  endfunction

endpackage

@@ rtl/spv_div_cell.sv @@
module spv_div_cell (
  input  logic          clk,
  input  logic          en,
  input  spv_pkg::div_t d_i,
  output spv_pkg::div_t d_o
);
  import spv_pkg::*;

  logic [REM_W:0] trial;
  logic           ge;
  div_t           d_nxt;
  div_t           d_r;

  always_comb begin
    trial = {d_i.rem, d_i.tail[TAIL_W-1]};
    ge = trial >= {1'b0, TURN_DEN};
    d_nxt.rem  = ge ? REM_W'(trial - {1'b0, TURN_DEN}) : trial[REM_W-1:0];
    d_nxt.tail = {d_i.tail[TAIL_W-2:0], 1'b0};
    d_nxt.quo  = {d_i.quo[ANG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

@@ rtl/spv_div_chain.sv @@
module spv_div_chain (
  input  logic                        clk,
  input  logic                        en,
  input  logic [spv_pkg::NUM_W-1:0]   num_i,
  output logic [spv_pkg::ANG_W-1:0]   quo_o
);
  import spv_pkg::*;

  div_t stage [DIV_CELLS+1];

  // The top bits are already below the denominator and seed the remainder.
  assign stage[0] = '{rem: REM_W'(num_i[NUM_W-1:TAIL_W]), tail: num_i[TAIL_W-1:0], quo: '0};

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    spv_div_cell u_cell (
      .clk (clk),
      .en  (en),
      .d_i (stage[i]),
      .d_o (stage[i+1])
    );
  end

  assign quo_o = stage[DIV_CELLS].quo;

endmodule

@@ rtl/spv_cordic_cell.sv @@
module spv_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  spv_pkg::cordic_t  d_i,
  input  logic [SIDE_W-1:0] side_i,
  output spv_pkg::cordic_t  d_o,
  output logic [SIDE_W-1:0] side_o
);
  import spv_pkg::*;

  cordic_t           d_nxt;
  cordic_t           d_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    d_nxt.flip = d_i.flip;
    if (d_i.z >= 0) begin
      d_nxt.x = d_i.x - (d_i.y >>> STEP);
      d_nxt.y = d_i.y + (d_i.x >>> STEP);
      d_nxt.z = d_i.z - ATAN_TURN[STEP];
    end else begin
      d_nxt.x = d_i.x + (d_i.y >>> STEP);
      d_nxt.y = d_i.y - (d_i.x >>> STEP);
      d_nxt.z = d_i.z + ATAN_TURN[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= side_i;
    end
  end

  assign d_o    = d_r;
  assign side_o = side_r;

endmodule

@@ rtl/spv_cordic_chain.sv @@
module spv_cordic_chain #(
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [spv_pkg::ANG_W-1:0]        angle_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic signed [spv_pkg::XY_W-1:0]  cos_o,
  output logic signed [spv_pkg::XY_W-1:0]  sin_o,
  output logic [SIDE_W-1:0]                side_o
);
  import spv_pkg::*;

  cordic_t                stage [CORDIC_STEPS+1];
  logic [SIDE_W-1:0]      side [CORDIC_STEPS+1];
  logic [ANG_W-1:0]       quarter;
  logic [ANG_W-1:0]       folded;
  logic                   flip;
  logic signed [XY_W-1:0] cos_r;
  logic signed [XY_W-1:0] sin_r;
  logic [SIDE_W-1:0]      side_r;

  // Angles outside the right half plane are turned by half a turn first.
  always_comb begin
    quarter = angle_i + 32'h40000000;
    flip    = quarter[ANG_W-1];
    folded  = flip ? angle_i + 32'h80000000 : angle_i;
    stage[0] = '{x: CORDIC_GAIN, y: '0, z: XY_W'($signed(folded)), flip: flip};
  end

  assign side[0] = side_i;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    spv_cordic_cell #(.STEP(i), .SIDE_W(SIDE_W)) u_cell (
      .clk    (clk),
      .en     (en),
      .d_i    (stage[i]),
      .side_i (side[i]),
      .d_o    (stage[i+1]),
      .side_o (side[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r  <= stage[CORDIC_STEPS].flip ? -stage[CORDIC_STEPS].x : stage[CORDIC_STEPS].x;
      sin_r  <= stage[CORDIC_STEPS].flip ? -stage[CORDIC_STEPS].y : stage[CORDIC_STEPS].y;
      side_r <= side[CORDIC_STEPS];
    end
  end

  assign cos_o  = cos_r;
  assign sin_o  = sin_r;
  assign side_o = side_r;

endmodule

@@ rtl/sun_position_vector_unit.sv @@
// Sun position vector from a whole Julian day number.
// The path from an input transfer to its result runs through the 48 division
// cells per angle, two 31-stage CORDIC chains and seven arithmetic stages.
// Throughput: one day number per cycle; the whole pipeline holds only while a
// result waits in the output register and another one arrives behind it.
// Reset clears the valid bits of the pipeline and of the output register.
module sun_position_vector_unit #(
  parameter int FRAC_BITS = spv_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [spv_pkg::DAY_W-1:0]          in_julian_day,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [spv_pkg::OUT_W-1:0]   out_sun_x,
  output logic signed [spv_pkg::OUT_W-1:0]   out_sun_y,
  output logic signed [spv_pkg::OUT_W-1:0]   out_sun_z
);
  import spv_pkg::*;

  localparam int DEPTH     = 2 + DIV_CELLS + 2 * (CORDIC_STEPS + 1) + 4;
  localparam int OUT_SHIFT = Q_SHIFT - FRAC_BITS;
  localparam int MAG_LO_W  = XY_W / 2;

  logic             en;
  logic             out_load;
  logic [DEPTH-1:0] v_r;
  logic             out_valid_r;

  logic signed [DAY_W:0]  day;
  logic signed [PROD_W-1:0] prod_lon_r, prod_anom_r, prod_obl_r;
  logic signed [SUM_W-1:0]  sum_lon, sum_anom, sum_obl;
  logic [NUM_W-1:0]         num_lon_r, num_anom_r, num_obl_r;
  logic [ANG_W-1:0]         lon_q, anom_q, obl_q;

  logic signed [XY_W-1:0] cm, sm, c2m, s2m;
  logic [ANG_W-1:0]       lon_a, obl_a;

  logic signed [PROD_W-1:0] pl1_r, pl2_r, pm1_r, pm2_r;
  logic [ANG_W-1:0]         lon3_r, obl3_r;

  logic signed [63:0]     r1, r2, r3, r4, mag_full;
  logic [ANG_W-1:0]       lam_nxt, lam4_r, obl4_r;
  logic signed [XY_W-1:0] mag4_r;

  logic signed [XY_W-1:0]          cl, sl, ce, se;
  logic [XY_W-MAG_LO_W-1:0]        mag_hi;
  logic [MAG_LO_W-1:0]             mag_lo;
  logic signed [XY_W-1:0]          mag5;

  logic signed [63:0]     px, py, rx, ry_full;
  logic signed [XY_W-1:0] rx5_r, ry5_r, ce5_r, se5_r;

  logic signed [63:0]     pyy, pzz, ryy, rzz;
  logic signed [XY_W-1:0] x6_r, y6_r, z6_r;

  logic signed [OUT_W-1:0] ox_nxt, oy_nxt, oz_nxt, ox_r, oy_r, oz_r;

  // The pipeline only holds when a valid item would land on a stalled result.
  assign en       = !(out_valid_r && out_stall && v_r[DEPTH-1]);
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  // Day offset and the rate terms of the three angles.
  assign day = $signed({1'b0, in_julian_day}) - J2000_DAY;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_lon_r  <= PROD_W'(RATE_LON) * PROD_W'(day);
      prod_anom_r <= PROD_W'(RATE_ANOM) * PROD_W'(day);
      prod_obl_r  <= PROD_W'(RATE_OBL) * PROD_W'(day);
    end
  end

  always_comb begin
    sum_lon  = BASE_LON + SUM_W'(prod_lon_r) + NUM_OFFSET;
    sum_anom = BASE_ANOM + SUM_W'(prod_anom_r) + NUM_OFFSET;
    sum_obl  = BASE_OBL + SUM_W'(prod_obl_r) + NUM_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_lon_r  <= sum_lon[NUM_W-1:0];
      num_anom_r <= sum_anom[NUM_W-1:0];
      num_obl_r  <= sum_obl[NUM_W-1:0];
    end
  end

  spv_div_chain u_div_lon  (.clk(clk), .en(en), .num_i(num_lon_r),  .quo_o(lon_q));
  spv_div_chain u_div_anom (.clk(clk), .en(en), .num_i(num_anom_r), .quo_o(anom_q));
  spv_div_chain u_div_obl  (.clk(clk), .en(en), .num_i(num_obl_r),  .quo_o(obl_q));

  spv_cordic_chain #(.SIDE_W(ANG_W)) u_cordic_m (
    .clk(clk), .en(en), .angle_i(anom_q), .side_i(obl_q),
    .cos_o(cm), .sin_o(sm), .side_o(obl_a)
  );

  spv_cordic_chain #(.SIDE_W(ANG_W)) u_cordic_2m (
    .clk(clk), .en(en), .angle_i({anom_q[ANG_W-2:0], 1'b0}), .side_i(lon_q),
    .cos_o(c2m), .sin_o(s2m), .side_o(lon_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pl1_r  <= PROD_W'(LAM_C1) * PROD_W'(sm);
      pl2_r  <= PROD_W'(LAM_C2) * PROD_W'(s2m);
      pm1_r  <= PROD_W'(MAG_C1) * PROD_W'(cm);
      pm2_r  <= PROD_W'(MAG_C2) * PROD_W'(c2m);
      lon3_r <= lon_a;
      obl3_r <= obl_a;
    end
  end

  // Equation of center and distance; the longitude wraps modulo one turn.
  always_comb begin
    r1       = rnd_shr(64'(pl1_r), Q_SHIFT);
    r2       = rnd_shr(64'(pl2_r), Q_SHIFT);
    r3       = rnd_shr(64'(pm1_r), Q_SHIFT);
    r4       = rnd_shr(64'(pm2_r), Q_SHIFT);
    lam_nxt  = lon3_r + r1[ANG_W-1:0] + r2[ANG_W-1:0];
    mag_full = 64'(MAG_BASE) - r3 - r4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lam4_r <= lam_nxt;
      mag4_r <= mag_full[XY_W-1:0];
      obl4_r <= obl3_r;
    end
  end

  // The distance rides along in two halves, one in each chain.
  spv_cordic_chain #(.SIDE_W(XY_W - MAG_LO_W)) u_cordic_lam (
    .clk(clk), .en(en), .angle_i(lam4_r), .side_i(mag4_r[XY_W-1:MAG_LO_W]),
    .cos_o(cl), .sin_o(sl), .side_o(mag_hi)
  );

  spv_cordic_chain #(.SIDE_W(MAG_LO_W)) u_cordic_obl (
    .clk(clk), .en(en), .angle_i(obl4_r), .side_i(mag4_r[MAG_LO_W-1:0]),
    .cos_o(ce), .sin_o(se), .side_o(mag_lo)
  );

  assign mag5 = $signed({mag_hi, mag_lo});

  always_comb begin
    px      = 64'(mag5) * 64'(cl);
    py      = 64'(mag5) * 64'(sl);
    rx      = rnd_shr(px, Q_SHIFT);
    ry_full = rnd_shr(py, Q_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx5_r <= rx[XY_W-1:0];
      ry5_r <= ry_full[XY_W-1:0];
      ce5_r <= ce;
      se5_r <= se;
    end
  end

  always_comb begin
    pyy = 64'(ry5_r) * 64'(ce5_r);
    pzz = 64'(ry5_r) * 64'(se5_r);
    ryy = rnd_shr(pyy, Q_SHIFT);
    rzz = rnd_shr(pzz, Q_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x6_r <= rx5_r;
      y6_r <= ryy[XY_W-1:0];
      z6_r <= rzz[XY_W-1:0];
    end
  end

  always_comb begin
    ox_nxt = sat_out(rnd_shr(64'(x6_r), OUT_SHIFT));
    oy_nxt = sat_out(rnd_shr(64'(y6_r), OUT_SHIFT));
    oz_nxt = sat_out(rnd_shr(64'(z6_r), OUT_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= v_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sun_x = ox_r;
  assign out_sun_y = oy_r;
  assign out_sun_z = oz_r;

endmodule
